// ===== design/rpnp_pkg.sv =====
`timescale 1ns / 1ps

package rpnp_pkg;

    localparam logic [7:0] HASH_CHAR    = 8'h23;
    localparam logic [3:0] DECIMAL_BASE = 4'd10;
    localparam logic [6:0] MIN_BASE     = 7'd2;
    localparam logic [6:0] MAX_BASE     = 7'd36;
    localparam logic [6:0] BASE_SAT     = 7'd127;
    localparam logic [5:0] NO_DIGIT     = 6'h3F;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_BAD_BASE  = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_out_item;

    // ascii digit or letter to its value, NO_DIGIT otherwise
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        d = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 6'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = 6'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = 6'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

endpackage

// ===== design/radix_prefixed_number_parser.sv =====
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// in      | input     | i_in_valid, o_in_stall  | i_in_data  (char_code, last_char)
// out     | output    | o_out_valid, i_out_stall| o_out_data (value, status)
//
// one character per cycle while o_in_stall is low; a character is registered
// at the input, then folded into the parse state with one value * base + digit
// step; the result is registered as the last character leaves the input register
// i_rst_n low (synchronous) clears the parse state and both valid flags
// a stalled result holds the next literal's last character in the input
// register; the characters before it keep flowing while a result waits

module radix_prefixed_number_parser
    import rpnp_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int PROD_WIDTH = VALUE_WIDTH + 7;

    t_in_item                 r_in;
    logic                     r_in_valid;
    logic                     r_after_hash;
    logic [6:0]               r_base;
    logic [VALUE_WIDTH-1:0]   r_value;
    logic                     r_digit_err;
    logic                     r_overflow;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     u_after_hash;
    logic [6:0]               u_base;
    logic [VALUE_WIDTH-1:0]   u_value;
    logic                     u_digit_err;
    logic                     u_overflow;
    logic [5:0]               digit;
    logic [10:0]              base_next;
    logic [PROD_WIDTH-1:0]    prod;
    logic                     base_ok_cur;
    logic                     base_ok_upd;
    logic                     out_free;
    logic                     advance;
    logic                     in_take;
    t_status                  status;
    t_out_item                n_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in.last_char || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign digit       = digit_of(r_in.char_code);
    assign base_ok_cur = (r_base >= MIN_BASE) && (r_base <= MAX_BASE);
    assign base_next   = 11'(r_base) * 11'(DECIMAL_BASE) + 11'(digit[3:0]);
    assign prod        = PROD_WIDTH'(r_value) * PROD_WIDTH'(r_base[5:0])
                       + PROD_WIDTH'(digit);

    always_comb begin
        u_after_hash = r_after_hash;
        u_base       = r_base;
        u_value      = r_value;
        u_digit_err  = r_digit_err;
        u_overflow   = r_overflow;
        if (!r_after_hash) begin
            if (r_in.char_code == HASH_CHAR) begin
                u_after_hash = 1'b1;
            end else if (digit >= 6'(DECIMAL_BASE)) begin
                u_digit_err = 1'b1;
            end else begin
                u_base = (base_next > 11'(BASE_SAT)) ? BASE_SAT : base_next[6:0];
            end
        end else if (base_ok_cur) begin
            if ({1'b0, digit} >= r_base) begin
                u_digit_err = 1'b1;
            end else begin
                // anything above the value width means the value no longer fits
                if (prod[PROD_WIDTH-1:VALUE_WIDTH] != '0) begin
                    u_overflow = 1'b1;
                end
                u_value = prod[VALUE_WIDTH-1:0];
            end
        end
    end

    assign base_ok_upd = (u_base >= MIN_BASE) && (u_base <= MAX_BASE);

    always_comb begin
        n_out.value = '0;
        if (u_digit_err) begin
            status = ST_BAD_DIGIT;
        end else if (!base_ok_upd) begin
            status = ST_BAD_BASE;
        end else if (u_overflow) begin
            status = ST_TOO_LARGE;
        end else begin
            status = ST_OK;
            if (u_after_hash) begin
                n_out.value = 64'(u_value);
            end
        end
        n_out.status = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_after_hash <= 1'b0;
            r_base       <= '0;
            r_value      <= '0;
            r_digit_err  <= 1'b0;
            r_overflow   <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= advance && r_in.last_char;
            end
            if (advance) begin
                if (r_in.last_char) begin
                    // literal done, start the next one clean
                    r_after_hash <= 1'b0;
                    r_base       <= '0;
                    r_value      <= '0;
                    r_digit_err  <= 1'b0;
                    r_overflow   <= 1'b0;
                end else begin
                    r_after_hash <= u_after_hash;
                    r_base       <= u_base;
                    r_value      <= u_value;
                    r_digit_err  <= u_digit_err;
                    r_overflow   <= u_overflow;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance && r_in.last_char) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/sv/rpnp_tb_pkg.sv =====
`timescale 1ns / 1ps

package rpnp_tb_pkg;

    import rpnp_pkg::*;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam int         NOT_DIGIT  = 99;

    class parse_scoreboard;

        // parse state, cleared after every literal
        bit        seen_hash;
        bit [6:0]  radix;
        bit [63:0] folded_value;
        bit        digit_bad;
        bit        value_overflow;

        t_out_item expected_results[$];
        int        errors;

        function new();
            clear_parse();
            errors = 0;
        endfunction

        function void clear_parse();
            seen_hash      = 1'b0;
            radix          = '0;
            folded_value   = '0;
            digit_bad      = 1'b0;
            value_overflow = 1'b0;
        endfunction

        function int char_value(bit [7:0] c);
            if (c >= CH_ZERO && c < CH_ZERO + 10) begin
                return int'(c - CH_ZERO);
            end else if (c >= CH_LOWER_A && c < CH_LOWER_A + 26) begin
                return int'(c - CH_LOWER_A) + 10;
            end else if (c >= CH_UPPER_A && c < CH_UPPER_A + 26) begin
                return int'(c - CH_UPPER_A) + 10;
            end
            return NOT_DIGIT;
        endfunction

        function bit radix_in_range();
            return radix >= MIN_BASE && radix <= MAX_BASE;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // fold one accepted character, queue a result on the last one
        function void note_char(t_in_item it);
            int        d;
            int        next_radix;
            bit [71:0] wide;
            t_out_item res;
            d = char_value(it.char_code);
            if (!seen_hash) begin
                if (it.char_code == HASH_CHAR) begin
                    seen_hash = 1'b1;
                end else if (d >= 10) begin
                    digit_bad = 1'b1;
                end else begin
                    next_radix = int'(radix) * 10 + d;
                    radix = (next_radix > BASE_SAT) ? BASE_SAT : 7'(next_radix);
                end
            end else if (radix_in_range()) begin
                if (d >= int'(radix)) begin
                    digit_bad = 1'b1;
                end else begin
                    wide = {8'b0, folded_value} * radix + 72'(d);
                    if (wide[71:64] != 0) begin
                        value_overflow = 1'b1;
                    end
                    folded_value = wide[63:0];
                end
            end
            if (it.last_char) begin
                res.value = '0;
                if (digit_bad) begin
                    res.status = ST_BAD_DIGIT;
                end else if (!radix_in_range()) begin
                    res.status = ST_BAD_BASE;
                end else if (value_overflow) begin
                    res.status = ST_TOO_LARGE;
                end else begin
                    res.status = ST_OK;
                    res.value  = seen_hash ? folded_value : '0;
                end
                expected_results.push_back(res);
                clear_parse();
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: value %h, status %0d", got.value, got.status);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.value !== want.value) begin
                $error("value: expected %h, got %h", want.value, got.value);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import rpnp_pkg::*;
    import rpnp_tb_pkg::*;

    localparam int TARGET_CHARS = 650;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 3000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    parse_scoreboard sb;
    int chars_sent = 0;
    int stuck_cycles = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    radix_prefixed_number_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sends one literal, last_char set on its final character
    task automatic send_chars(input byte unsigned chars[$]);
        t_in_item it;
        foreach (chars[i]) begin
            if (!no_gaps && $urandom_range(0, 99) < 9) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            it.char_code = chars[i];
            it.last_char = (i == chars.size() - 1);
            i_in_valid <= 1'b1;
            i_in_data  <= it;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            sb.note_char(it);
            chars_sent++;
        end
    endtask

    task automatic send_text(input string s);
        byte unsigned chars[$];
        for (int i = 0; i < s.len(); i++) begin
            chars.push_back(s[i]);
        end
        send_chars(chars);
    endtask

    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic byte unsigned digit_char(input int d);
        if (d < 10) begin
            return CH_ZERO + 8'(d);
        end
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
    endfunction

    task automatic send_random_literal();
        byte unsigned chars[$];
        string        radix_text;
        int           kind;
        int           radix;
        int           span;
        int           ndigits;
        bit           top_digits;
        logic [63:0]  rest;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // base#digits in a valid base, often sized around the overflow point; some lack the hash or are corrupted
            radix = $urandom_range(MIN_BASE, MAX_BASE);
            radix_text = $sformatf("%0d", radix);
            if ($urandom_range(0, 9) == 0) begin
                chars.push_back(CH_ZERO);
            end
            for (int i = 0; i < radix_text.len(); i++) begin
                chars.push_back(radix_text[i]);
            end
            if ($urandom_range(0, 19) != 0) begin
                chars.push_back(HASH_CHAR);
                rest = '1;
                span = 0;
                while (rest != 0) begin
                    rest = rest / radix;
                    span++;
                end
                ndigits = $urandom_range(0, 1) ? $urandom_range(span - 1, span + 1)
                                               : $urandom_range(0, span);
                top_digits = ($urandom_range(0, 4) == 0);
                for (int i = 0; i < ndigits; i++) begin
                    chars.push_back(digit_char(top_digits ? radix - 1
                                                          : $urandom_range(0, radix - 1)));
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                // corrupt one character: digit too big, second hash or any byte
                case ($urandom_range(0, 2))
                    0: chars[$urandom_range(0, chars.size() - 1)] =
                           (radix < MAX_BASE) ? digit_char($urandom_range(radix, MAX_BASE - 1))
                                              : HASH_CHAR;
                    1: chars[$urandom_range(0, chars.size() - 1)] = HASH_CHAR;
                    default: chars[$urandom_range(0, chars.size() - 1)] =
                                 8'($urandom_range(0, 255));
                endcase
            end
        end else if (kind < 85) begin
            // base out of range, empty or very long
            radix = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) : $urandom_range(37, 999);
            if (radix > 1 || $urandom_range(0, 1)) begin
                radix_text = $sformatf("%0d", radix);
                for (int i = 0; i < radix_text.len(); i++) begin
                    chars.push_back(radix_text[i]);
                end
                repeat ($urandom_range(0, 6)) chars.push_back(digit_char($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 1) || chars.size() == 0) begin
                chars.push_back(HASH_CHAR);
                repeat ($urandom_range(0, 8)) chars.push_back(digit_char($urandom_range(0, 35)));
            end
        end else begin
            repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
        end
        send_chars(chars);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_stall <= !no_gaps && ($urandom_range(0, 99) < 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        byte unsigned raw[$];
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("16#ff");
        send_text("#");
        send_text("2#");
        send_text("36#Zz");
        send_text("37#1");
        send_text("8#9");
        send_text("10");
        raw.push_back(8'hFF);
        raw.push_back(8'h00);
        send_chars(raw);
        wait_until_drained();

        for (int n = 0; chars_sent < TARGET_CHARS; n++) begin
            no_gaps = (n >= 15 && n < 30);
            if (n == 8) begin
                hold_req = 1'b1;
            end
            if (n == 35) begin
                wait_until_drained();
            end
            send_random_literal();
        end

        wait_until_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
